// ----- sv/sha256_message_hasher_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef SHA256_MESSAGE_HASHER_UNIT_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_UNIT_DEFINES_SVH

// property must hold at every rising clock edge out of reset
`define SHA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true out of reset
`define SHA_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ----- sv/sha256mh_pkg.sv -----
// shared types, round constants and initial hash values of the sha-256 hasher
package sha256mh_pkg;

    localparam int NUM_HASH    = 8;
    localparam int NUM_ROUNDS  = 64;
    localparam int WIN_DEPTH   = 16;
    localparam int MAX_BYTES   = 4;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTES,
        ST_COMP,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } state_t;

    // controls for the byte packer and message schedule window
    typedef struct packed {
        logic       byte_we;
        logic       word_done;
        logic [7:0] byte_val;
        logic       shift;
    } sched_ctl_t;

    // controls for the compression round unit
    typedef struct packed {
        logic load_work;
        logic round_en;
        logic hash_add;
        logic hash_init;
    } round_ctl_t;

    localparam word_t HASH_IV [NUM_HASH] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ----- sv/sha256mh_sched.sv -----
// byte packer and sixteen-word message schedule window
module sha256mh_sched
    import sha256mh_pkg::*;
(
    input  logic       aclk,
    input  sched_ctl_t ctl,
    output word_t      w_out
);

    logic [23:0] acc_reg, acc_next;
    word_t       win_reg  [WIN_DEPTH];
    word_t       win_next [WIN_DEPTH];
    word_t       word_new;
    word_t       expand;
    word_t       s0, s1;

    function automatic word_t small_sigma0(word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    assign word_new = {acc_reg, ctl.byte_val};
    assign s0       = small_sigma0(win_reg[1]);
    assign s1       = small_sigma1(win_reg[14]);
    assign expand   = s1 + win_reg[9] + s0 + win_reg[0];
    assign w_out    = win_reg[0];

    always_comb begin
        acc_next = acc_reg;
        win_next = win_reg;
        if (ctl.byte_we) begin
            acc_next = word_new[23:0];
        end
        // a finished word or an expanded word enters at the top
        if ((ctl.byte_we && ctl.word_done) || ctl.shift) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[WIN_DEPTH - 1] = ctl.shift ? expand : word_new;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        win_reg <= win_next;
    end

endmodule

// ----- sv/sha256mh_round.sv -----
// compression round unit: working variables, hash words and digest readout
module sha256mh_round
    import sha256mh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  round_ctl_t ctl,
    input  word_t      k_in,
    input  word_t      w_in,
    input  logic [2:0] out_idx,
    output word_t      digest_word
);

    word_t hash_reg  [NUM_HASH];
    word_t hash_next [NUM_HASH];
    word_t work_reg  [NUM_HASH];
    word_t work_next [NUM_HASH];
    word_t t1, t2;
    word_t a, e;

    function automatic word_t big_sigma0(word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    assign a  = work_reg[0];
    assign e  = work_reg[4];
    assign t1 = work_reg[7] + big_sigma1(e) + ((e & work_reg[5]) ^ (~e & work_reg[6]))
              + k_in + w_in;
    assign t2 = big_sigma0(a) + ((a & work_reg[1]) ^ (a & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));

    assign digest_word = hash_reg[out_idx];

    always_comb begin
        work_next = work_reg;
        if (ctl.load_work) begin
            work_next = hash_reg;
        end else if (ctl.round_en) begin
            for (int i = 1; i < NUM_HASH; i++) begin
                work_next[i] = work_reg[i - 1];
            end
            work_next[0] = t1 + t2;
            work_next[4] = work_reg[3] + t1;
        end
    end

    always_comb begin
        hash_next = hash_reg;
        if (ctl.hash_init) begin
            hash_next = HASH_IV;
        end else if (ctl.hash_add) begin
            for (int i = 0; i < NUM_HASH; i++) begin
                hash_next[i] = hash_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= HASH_IV;
        end else begin
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

endmodule

// ----- sv/sha256_message_hasher_unit.sv -----
// top level of the sha-256 message hasher: request sequencer and stream ports
//
// input stream: each request carries up to four message bytes in s_axis_tdata,
// first byte in bits 31..24, the number of valid leading bytes in s_axis_tuser
// (values above four count as four) and s_axis_tlast on the final word.
// output stream: after a final word the block sends eight digest words,
// hash word 0 first, index in m_axis_tuser, m_axis_tlast on word 7.
// sequence: a request is taken while the block is idle, then its bytes are packed
// one per cycle, held while a full 64-byte block runs its 64 rounds on the single
// shared round unit and then the hash update. on a final word the padding bytes
// also go through the byte packer one per cycle, with the same hold (9 to 72 bytes,
// one or two extra blocks), then the digest words follow back to back.
// a new request is taken only once the bytes of the last one are packed and any
// full block that they closed is compressed.
// s_axis_tready is high only while the block is idle.
// reset (aresetn low, synchronous) loads the initial hash values and clears
// the byte count; after the eighth digest word the block re-initializes itself.
// a stalled receiver holds the current digest word and blocks new input.
module sha256_message_hasher_unit
    import sha256mh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_word
    input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
    input  logic        s_axis_tlast,   // end_of_message
    // digest channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    localparam logic [2:0] LAST_IDX = 3'(NUM_HASH - 1);
    localparam logic [5:0] LAST_RND = 6'(NUM_ROUNDS - 1);
    localparam logic [2:0] SAT_CNT  = 3'(MAX_BYTES);

    state_t      state_reg, state_next;
    word_t       data_reg, data_next;
    logic [2:0]  left_reg, left_next;
    logic        last_reg, last_next;
    logic        pad_reg, pad_next;       // padding under way
    logic        mark_reg, mark_next;     // 0x80 marker already written
    logic        lenblk_reg, lenblk_next; // current block carries the length
    logic        fin_reg, fin_next;       // final block packed, digest after it
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] total_reg, total_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  oidx_reg, oidx_next;

    logic        s_fire, m_fire;
    logic [2:0]  cnt_sat;
    logic        byte_we;
    logic        block_end;
    logic [7:0]  pad_byte;
    logic [63:0] len_bits;
    sched_ctl_t  sched_ctl;
    round_ctl_t  round_ctl;
    word_t       w_cur;

    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign m_fire    = m_axis_tvalid && m_axis_tready;
    assign cnt_sat   = (s_axis_tuser > SAT_CNT) ? SAT_CNT : s_axis_tuser;
    assign byte_we   = (state_reg == ST_BYTES) || (state_reg == ST_PAD);
    assign block_end = byte_we && (pos_reg == LAST_POS);
    assign len_bits  = {total_reg[60:0], 3'b000};

    // padding byte: marker, then zeros, then the bit length big-endian
    always_comb begin
        if (!mark_reg) begin
            pad_byte = PAD_MARK;
        end else if (lenblk_reg && (pos_reg >= LEN_POS)) begin
            pad_byte = len_bits[{~pos_reg[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (cnt_sat != 3'd0) begin
                        state_next = ST_BYTES;
                    end else if (s_axis_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_BYTES: begin
                if (block_end) begin
                    state_next = ST_COMP;
                end else if (left_reg == 3'd1) begin
                    state_next = last_reg ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                if (block_end) begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                if (rnd_reg == LAST_RND) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                // resume whatever the full block interrupted
                if (fin_reg) begin
                    state_next = ST_OUT;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else if (left_reg != 3'd0) begin
                    state_next = ST_BYTES;
                end else if (last_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_fire && (oidx_reg == LAST_IDX)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and unit controls
    always_comb begin
        s_axis_tready       = 1'b0;
        m_axis_tvalid       = 1'b0;
        sched_ctl.byte_we   = byte_we;
        sched_ctl.word_done = (pos_reg[1:0] == 2'b11);
        sched_ctl.byte_val  = (state_reg == ST_PAD) ? pad_byte : data_reg[31:24];
        sched_ctl.shift     = 1'b0;
        round_ctl.load_work = block_end;
        round_ctl.round_en  = 1'b0;
        round_ctl.hash_add  = 1'b0;
        round_ctl.hash_init = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_BYTES, ST_PAD: ;
            ST_COMP: begin
                sched_ctl.shift    = 1'b1;
                round_ctl.round_en = 1'b1;
            end
            ST_FINAL: round_ctl.hash_add = 1'b1;
            ST_OUT: begin
                m_axis_tvalid       = 1'b1;
                round_ctl.hash_init = m_fire && (oidx_reg == LAST_IDX);
            end
            default: ;
        endcase
    end

    assign m_axis_tuser = oidx_reg;
    assign m_axis_tlast = (oidx_reg == LAST_IDX);

    // request bookkeeping
    always_comb begin
        data_next   = data_reg;
        left_next   = left_reg;
        last_next   = last_reg;
        pad_next    = pad_reg | (state_next == ST_PAD);
        mark_next   = mark_reg;
        lenblk_next = lenblk_reg;
        fin_next    = fin_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        rnd_next    = rnd_reg;
        oidx_next   = oidx_reg;

        if (s_fire) begin
            data_next = s_axis_tdata;
            left_next = cnt_sat;
            last_next = s_axis_tlast;
        end
        if (byte_we) begin
            pos_next = pos_reg + 6'd1;
        end
        if (state_reg == ST_BYTES) begin
            data_next  = {data_reg[23:0], 8'h00};
            left_next  = left_reg - 3'd1;
            total_next = total_reg + 64'd1;
        end
        if (state_reg == ST_PAD) begin
            mark_next = 1'b1;
            // length goes in the block where the marker leaves room, else the next one
            if ((!mark_reg && (pos_reg < LEN_POS)) || block_end) begin
                lenblk_next = 1'b1;
            end
            if (block_end && lenblk_reg) begin
                fin_next = 1'b1;
            end
        end
        if (state_reg == ST_COMP) begin
            rnd_next = rnd_reg + 6'd1;
        end
        if (m_fire) begin
            oidx_next = oidx_reg + 3'd1;
            if (oidx_reg == LAST_IDX) begin
                total_next  = 64'd0;
                pos_next    = 6'd0;
                last_next   = 1'b0;
                pad_next    = 1'b0;
                mark_next   = 1'b0;
                lenblk_next = 1'b0;
                fin_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            left_reg   <= 3'd0;
            last_reg   <= 1'b0;
            pad_reg    <= 1'b0;
            mark_reg   <= 1'b0;
            lenblk_reg <= 1'b0;
            fin_reg    <= 1'b0;
            pos_reg    <= 6'd0;
            total_reg  <= 64'd0;
            rnd_reg    <= 6'd0;
            oidx_reg   <= 3'd0;
        end else begin
            state_reg  <= state_next;
            left_reg   <= left_next;
            last_reg   <= last_next;
            pad_reg    <= pad_next;
            mark_reg   <= mark_next;
            lenblk_reg <= lenblk_next;
            fin_reg    <= fin_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            rnd_reg    <= rnd_next;
            oidx_reg   <= oidx_next;
        end
    end

    // payload holding register, no reset needed
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    sha256mh_sched u_sched (
        .aclk  (aclk),
        .ctl   (sched_ctl),
        .w_out (w_cur)
    );

    sha256mh_round u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (round_ctl),
        .k_in        (ROUND_K[rnd_reg]),
        .w_in        (w_cur),
        .out_idx     (oidx_reg),
        .digest_word (m_axis_tdata)
    );

endmodule

// ----- sv/sha256mh_checker.sv -----
// port-level checker for the sha-256 hasher and its bind to the top level
`include "sha256_message_hasher_unit_defines.svh"

module sha256mh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled digest word holds
    `SHA_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "digest word changed while stalled")

    // no new request while a digest is pending
    `SHA_NEVER(a_no_overlap, aclk, aresetn, m_axis_tvalid && s_axis_tready, "input ready during digest output")

    // digest words follow in index order without gaps
    `SHA_ASSERT(a_word_order, aclk, aresetn, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && (m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)), "digest word index out of order")

    // last flag only on word seven
    `SHA_ASSERT(a_last_idx, aclk, aresetn, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)), "last flag not on word seven")

    // block is ready again right after the digest
    `SHA_ASSERT(a_ready_after, aclk, aresetn, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready, "block not ready after digest")

endmodule

bind sha256_message_hasher_unit sha256mh_checker u_sha256mh_checker (.*);
